[hw/rtl/utf8l1_pkg.sv]
// ----------------------------------------------------------------------------
// utf8l1_pkg: shared types and a helper for the UTF-8 to Latin-1 decoder
// Result kinds, field widths and the per-length legal-range check.
// ----------------------------------------------------------------------------
package utf8l1_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned CNT_W  = 3;
	localparam int unsigned ACC_W  = 31;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ACC_W-1:0]  acc_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_CHAR  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ABORT = 2'd2
	} kind_t;

	// True when a completed value fits the legal range for its octet count.
	function automatic logic in_legal_range(input cnt_t len, input acc_t v);
		logic ok;
		begin
			unique case (len)
				3'd1: ok = (v <= 31'h7f);
				3'd2: ok = (v >= 31'h80) && (v <= 31'h7ff);
				3'd3: ok = (v >= 31'h800) && (v <= 31'hffff);
				3'd4: ok = (v >= 31'h10000) && (v <= 31'h1fffff);
				3'd5: ok = (v >= 31'h200000) && (v <= 31'h3ffffff);
				3'd6: ok = (v >= 31'h4000000) && (v <= 31'h7fffffff);
				default: ok = 1'b0;
			endcase
			return ok;
		end
	endfunction

endpackage

[hw/rtl/utf8_to_latin1_decoder_top.sv]
// ----------------------------------------------------------------------------
// utf8_to_latin1_decoder_top: byte-wide UTF-8 to Latin-1 stream decoder
// One UTF-8 byte in per transfer, at most one Latin-1 result out per byte.
// ----------------------------------------------------------------------------
// Usage: feed the string one byte per slave transfer; the block takes one
// byte per clock while ready, and each result appears in the cycle after the
// byte that completes it. The only register between the two sides is the
// result register, and the slave side stays ready whenever that register is
// empty or is being drained in the same cycle, so a stalled master side
// holds the input back by exactly one result. Sequences of 1 to 6 octets are
// decoded; a completed code point whose value is legal for its length gives
// its low eight bits with tuser = character. Overlong, out-of-range or
// broken sequences vanish without a result. A zero byte always gives an end
// marker and clears all decoding state. A byte that cannot open a sequence
// gives an abort result, after which every byte is dropped until the zero.
module utf8_to_latin1_decoder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// slave side: input bytes
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [utf8l1_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
	// master side: results
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [utf8l1_pkg::BYTE_W-1:0] m_tdata,   // [7:0] latin_byte
	output logic [utf8l1_pkg::KIND_W-1:0] m_tuser    // [1:0] result_kind
);
	import utf8l1_pkg::*;

	// Decoding state.
	cnt_t  pend_q;      // continuation bytes still expected
	cnt_t  len_q;       // octet count of the current sequence
	acc_t  acc_q;       // partly built code point
	logic  discard_q;   // abort seen, drop bytes until the terminator

	// Result register.
	logic  out_valid_q;
	byte_t out_byte_q;
	kind_t out_kind_q;

	// Next-state and result candidates.
	cnt_t  pend_n;
	cnt_t  len_n;
	acc_t  acc_n;
	logic  discard_n;
	acc_t  cand;
	acc_t  cont_bits;
	logic  complete;
	logic  res_valid;
	byte_t res_byte;
	kind_t res_kind;
	logic  in_xfer;
	byte_t c;

	assign c        = s_tdata;
	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_kind_q;

	// Place the six payload bits of a continuation byte by how many remain.
	always_comb begin
		unique case (pend_q)
			3'd2:    cont_bits = {25'd0, c[5:0]} << 6;
			3'd3:    cont_bits = {25'd0, c[5:0]} << 12;
			3'd4:    cont_bits = {25'd0, c[5:0]} << 18;
			3'd5:    cont_bits = {25'd0, c[5:0]} << 24;
			default: cont_bits = {25'd0, c[5:0]};
		endcase
	end

	always_comb begin
		pend_n    = pend_q;
		len_n     = len_q;
		acc_n     = acc_q;
		discard_n = discard_q;
		cand      = acc_q;
		complete  = 1'b0;
		res_valid = 1'b0;
		res_byte  = '0;
		res_kind  = KIND_CHAR;

		priority if (c == 8'h00) begin
			// Terminator: clear everything and mark the end.
			pend_n    = '0;
			len_n     = '0;
			acc_n     = '0;
			discard_n = 1'b0;
			res_valid = 1'b1;
			res_kind  = KIND_END;
		end else if (discard_q) begin
			// Drop the byte, hold all state.
		end else if (pend_q == 3'd0) begin
			// Expecting a lead byte.
			priority if ((c & 8'hfe) == 8'hfc) begin
				cand = {c[0], 30'd0};
				len_n = 3'd6; pend_n = 3'd5;
			end else if ((c & 8'hfc) == 8'hf8) begin
				cand = {5'd0, c[1:0], 24'd0};
				len_n = 3'd5; pend_n = 3'd4;
			end else if ((c & 8'hf8) == 8'hf0) begin
				cand = {10'd0, c[2:0], 18'd0};
				len_n = 3'd4; pend_n = 3'd3;
			end else if ((c & 8'hf0) == 8'he0) begin
				cand = {15'd0, c[3:0], 12'd0};
				len_n = 3'd3; pend_n = 3'd2;
			end else if ((c & 8'he0) == 8'hc0) begin
				cand = {20'd0, c[4:0], 6'd0};
				len_n = 3'd2; pend_n = 3'd1;
			end else if (c[7] == 1'b0) begin
				cand = {23'd0, c};
				len_n = 3'd1; pend_n = 3'd0;
				complete = 1'b1;
			end else begin
				// Invalid lead byte: abort and start discarding.
				cand      = '0;
				len_n     = '0;
				pend_n    = '0;
				discard_n = 1'b1;
				res_valid = 1'b1;
				res_kind  = KIND_ABORT;
			end
			acc_n = cand;
		end else if (c[7:6] == 2'b10) begin
			// Continuation byte: merge its bits and count down.
			cand     = acc_q | cont_bits;
			acc_n    = cand;
			pend_n   = pend_q - 3'd1;
			complete = (pend_q == 3'd1);
		end else begin
			// Broken sequence: consume the byte, drop the sequence.
			pend_n = '0;
			len_n  = '0;
			acc_n  = '0;
		end

		if (complete) begin
			pend_n = '0;
			len_n  = '0;
			acc_n  = '0;
			if (in_legal_range(len_q == 3'd0 ? 3'd1 : len_n, cand) && pend_q == 3'd0) begin
				res_valid = 1'b1;
				res_byte  = cand[7:0];
			end else if (in_legal_range(len_q, cand) && pend_q != 3'd0) begin
				res_valid = 1'b1;
				res_byte  = cand[7:0];
			end
		end
	end

	// Advance the decoding state on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			len_q     <= '0;
			acc_q     <= '0;
			discard_q <= 1'b0;
		end else if (in_xfer) begin
			pend_q    <= pend_n;
			len_q     <= len_n;
			acc_q     <= acc_n;
			discard_q <= discard_n;
		end
	end

	// Result valid: load on a producing byte, drop once the master takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: hold until replaced by the next result.
	always_ff @(posedge clk) begin
		if (in_xfer && res_valid) begin
			out_byte_q <= res_byte;
			out_kind_q <= res_kind;
		end
	end

endmodule

[hw/rtl/utf8l1_checker.sv]
// ----------------------------------------------------------------------------
// utf8l1_checker: port-level checks for the UTF-8 to Latin-1 decoder
// Watches the stream ports of the top level and flags illegal behavior.
// ----------------------------------------------------------------------------
module utf8l1_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [utf8l1_pkg::BYTE_W-1:0] s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [utf8l1_pkg::BYTE_W-1:0] m_tdata,
	input logic [utf8l1_pkg::KIND_W-1:0] m_tuser
);
	import utf8l1_pkg::*;

	// A terminator byte always yields an end marker in the next cycle.
	a_end_follows_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata == 8'h00)
		|=> m_tvalid && (m_tuser == KIND_END))
		else $error("terminator did not produce an end marker");

	// End and abort results carry a zero byte; no unused kind appears.
	a_kind_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_CHAR)
		|-> (m_tdata == 8'h00) && ((m_tuser == KIND_END) || (m_tuser == KIND_ABORT)))
		else $error("non-character result with bad payload or kind");

	// Input is taken whenever no result is waiting.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while result register empty");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind utf8_to_latin1_decoder_top utf8l1_checker u_utf8l1_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
